FILE: hw/rtl/multi_channel_countdown_timer_bank_assert.svh
// Assertion macros shared by the timer bank RTL.
// Included by name from the files that check their own logic; no other dependencies.
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_BANK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MCTB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define MCTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed: next-cycle implication");
`else
`define MCTB_ASSERT_NOW(label, clk, rst, ante, cons)
`define MCTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/mctb_pkg.sv
// Shared constants, codes and types of the countdown timer bank.
// No dependencies; every other RTL file but the assertion header imports it.
`default_nettype none

package mctb_pkg;

  // Bank geometry.
  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 16;

  // Fixed field widths of the words on the channels.
  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 3;
  localparam int COUNT_IN_W = 16;
  localparam int MASK_W     = 8;
  localparam int TIME_W     = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_INCREMENT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOTIFY_MASK    = 1'b1;

  // Oscillator counts per centisecond after reset.
  localparam logic [TIME_W-1:0] RESET_INCREMENT = 32'd36864;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POLL  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input word
    logic execute;  // apply the latched word and load the result register
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mctb_if.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on mctb_pkg for the field widths.
`default_nettype none

interface mctb_in_if;
  import mctb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [INDEX_W-1:0]    timer_index;
  logic [COUNT_IN_W-1:0] count;

  modport source (output valid, mode, timer_index, count, input ready);
  modport sink (input valid, mode, timer_index, count, output ready);
endinterface

interface mctb_out_if;
  import mctb_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [MASK_W-1:0] expired_mask;
  logic [TIME_W-1:0] centiseconds;
  logic [TIME_W-1:0] counter_now;

  modport source (output valid, status, expired_mask, centiseconds, counter_now, input ready);
  modport sink (input valid, status, expired_mask, centiseconds, counter_now, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mctb_datapath.sv
// Datapath of the timer bank: word latch, timer state, oscillator and match logic,
// and the result register. Depends on mctb_pkg; driven by mctb_ctrl commands.
`default_nettype none

module mctb_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  mctb_pkg::cmd_t              cmd,
  input  wire  [mctb_pkg::MODE_W-1:0]       mode,
  input  wire  [mctb_pkg::INDEX_W-1:0]      timer_index,
  input  wire  [mctb_pkg::COUNT_IN_W-1:0]   count,
  input  wire                               cfg_we,
  input  wire  [mctb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [mctb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              status,
  output logic [mctb_pkg::MASK_W-1:0]       expired_mask,
  output logic [mctb_pkg::TIME_W-1:0]       centiseconds,
  output logic [mctb_pkg::TIME_W-1:0]       counter_now
);
  import mctb_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0] tick_increment;
  logic [MASK_W-1:0] notify_mask;

  // Latched input word.
  logic [MODE_W-1:0]     item_mode;
  logic [INDEX_W-1:0]    item_index;
  logic [COUNT_IN_W-1:0] item_count;

  // Bank state.
  logic [COUNT_WIDTH-1:0] remaining [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  expired_flag;
  logic [TIME_W-1:0]      centisecond_count;
  logic [TIME_W-1:0]      oscillator_counter;
  logic [TIME_W-1:0]      match_value;
  logic                   match_pending;

  // Next-state values.
  logic [COUNT_WIDTH-1:0] remaining_next [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  expired_flag_next;
  logic [NUM_TIMERS-1:0]  reached_zero;
  logic [TIME_W-1:0]      centisecond_count_next;
  logic [TIME_W-1:0]      oscillator_counter_next;
  logic [TIME_W-1:0]      match_value_next;
  logic                   match_pending_next;
  logic [MASK_W-1:0]      mask_next;
  logic                   status_next;
  logic                   service;

  // Configuration writes; indexes beyond the list fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_increment <= RESET_INCREMENT;
      notify_mask    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_INCREMENT: tick_increment <= cfg_wdata[TIME_W-1:0];
        CFG_NOTIFY_MASK:    notify_mask    <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted word until the controller executes it.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode  <= mode;
      item_index <= timer_index;
      item_count <= count;
    end
  end

  // Update of the whole bank for one word; all timers step in parallel.
  always_comb begin
    remaining_next          = remaining;
    expired_flag_next       = expired_flag;
    reached_zero            = '0;
    centisecond_count_next  = centisecond_count;
    oscillator_counter_next = oscillator_counter;
    match_value_next        = match_value;
    match_pending_next      = match_pending;
    mask_next               = '0;
    status_next             = 1'b0;
    service                 = (item_mode == MODE_POLL) && match_pending;

    case (item_mode)
      MODE_TICK: begin
        oscillator_counter_next = oscillator_counter + 32'd1;
        if (oscillator_counter_next == match_value) begin
          match_pending_next = 1'b1;
        end
      end
      MODE_SET: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (int'(item_index) == i) begin
            remaining_next[i]    = COUNT_WIDTH'(item_count);
            expired_flag_next[i] = 1'b0;
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (int'(item_index) == i) begin
            remaining_next[i]    = '0;
            expired_flag_next[i] = 1'b0;
          end
        end
      end
      MODE_POLL: begin
        if (service) begin
          match_pending_next     = 1'b0;
          match_value_next       = match_value + tick_increment;
          centisecond_count_next = centisecond_count + 32'd1;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (remaining[i] != '0) begin
              remaining_next[i] = remaining[i] - COUNT_WIDTH'(1);
              if (remaining[i] == COUNT_WIDTH'(1)) begin
                expired_flag_next[i] = 1'b1;
                reached_zero[i]      = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    // Only the first eight timers have a notify bit.
    for (int j = 0; j < MASK_W; j++) begin
      if (j < NUM_TIMERS) begin
        mask_next[j] = reached_zero[j] & notify_mask[j];
      end
    end

    // Status of the addressed timer after this word; zero beyond the bank.
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (int'(item_index) == i) begin
        status_next = expired_flag_next[i];
      end
    end
  end

  // Bank state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        remaining[i] <= '0;
      end
      expired_flag       <= '0;
      centisecond_count  <= '0;
      oscillator_counter <= '0;
      match_value        <= RESET_INCREMENT;
      match_pending      <= 1'b0;
    end else if (cmd.execute) begin
      remaining          <= remaining_next;
      expired_flag       <= expired_flag_next;
      centisecond_count  <= centisecond_count_next;
      oscillator_counter <= oscillator_counter_next;
      match_value        <= match_value_next;
      match_pending      <= match_pending_next;
    end
  end

  // Result register; it holds while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status       <= status_next;
      expired_mask <= mask_next;
      centiseconds <= centisecond_count_next;
      counter_now  <= oscillator_counter_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mctb_ctrl.sv
// Controller of the timer bank: accepts a word, schedules its execution and
// tracks the result register. Depends on mctb_pkg and the assertion macros.
`default_nettype none
`include "multi_channel_countdown_timer_bank_assert.svh"

module mctb_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  output mctb_pkg::cmd_t  cmd
);
  import mctb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // A word is taken only when nothing is waiting for execution.
  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // Execute once the result register is free or is being emptied this cycle.
  assign cmd.execute = (state == S_EXEC) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `MCTB_ASSERT_NEXT(a_exec_loads_result, clk, rst, cmd.execute, out_valid)
  `MCTB_ASSERT_NEXT(a_capture_then_exec, clk, rst, cmd.capture, state == S_EXEC)
  `MCTB_ASSERT_NEXT(a_stall_holds_word, clk, rst,
    (state == S_EXEC) && out_valid && !out_ready, (state == S_EXEC) && out_valid)
  `MCTB_ASSERT_NOW(a_no_exec_when_idle, clk, rst, state == S_IDLE, !cmd.execute)

endmodule

`default_nettype wire

FILE: hw/rtl/multi_channel_countdown_timer_bank.sv
// Channel   Dir  Fields                                              Handshake
// item      in   mode, timer_index, count                            valid/ready
// result    out  status, expired_mask, centiseconds, counter_now     valid/ready
// cfg       in   cfg_index, cfg_wdata                                cfg_we, no wait
//
// Each word is first accepted into the input latch and then applied to all
// timers at once, which loads the result register.
// The next word is accepted while a result still waits to be taken; execution
// waits only while the result register is full and stalled.
// Reset is synchronous; there is no clearing pass.
// Top level of the countdown timer bank; depends on mctb_pkg, mctb_if,
// mctb_ctrl and mctb_datapath.
`default_nettype none

module multi_channel_countdown_timer_bank (
  input  wire                               clk,
  input  wire                               rst,
  mctb_in_if.sink                           item,
  mctb_out_if.source                        result,
  input  wire                               cfg_we,
  input  wire  [mctb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [mctb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mctb_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  // Sequencing of accept, execute and result delivery.
  mctb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // Timer state and result register.
  mctb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (item.mode),
    .timer_index  (item.timer_index),
    .count        (item.count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .status       (result.status),
    .expired_mask (result.expired_mask),
    .centiseconds (result.centiseconds),
    .counter_now  (result.counter_now)
  );

  assign item.ready   = in_ready;
  assign result.valid = out_valid;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench of the countdown timer bank: directed and random words
// go through the item channel and every result word is checked against a predictor.
// Depends on mctb_pkg, mctb_if and the multi_channel_countdown_timer_bank RTL.
`timescale 1ns / 1ps

module testbench;
  import mctb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 30;
  localparam int PHASES        = 6;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [INDEX_W-1:0]    timer_index;
    logic [COUNT_IN_W-1:0] count;
  } timer_word_t;

  typedef struct packed {
    logic              status;
    logic [MASK_W-1:0] expired_mask;
    logic [TIME_W-1:0] centiseconds;
    logic [TIME_W-1:0] counter_now;
  } timer_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  mctb_in_if  item_ch();
  mctb_out_if result_ch();

  multi_channel_countdown_timer_bank i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the bank and its registers.
  logic [COUNT_WIDTH-1:0] left_cs [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  expired_bits;
  logic [TIME_W-1:0]      cs_total;
  logic [TIME_W-1:0]      osc_now;
  logic [TIME_W-1:0]      match_at;
  logic                   match_latched;
  logic [TIME_W-1:0]      step_size;
  logic [MASK_W-1:0]      notify_bits;

  // Shadow of the oscillator and match kept by the word generator, used only to
  // steer tick runs so that they land on the armed match value.
  logic [TIME_W-1:0] gen_osc;
  logic [TIME_W-1:0] gen_match;
  logic [TIME_W-1:0] gen_step;
  logic              gen_latched;

  timer_word_t   pending_words [$];
  timer_result_t awaited_results [$];
  timer_word_t   drive_word;
  timer_word_t   seen_word;

  int words_queued;
  int words_taken_n;
  int results_checked;
  int services_n;
  int notified_n;
  int mismatch_count;
  int cycle_count;

  // Idling controls of the sender and the receiver.
  bit       gaps_on;
  bit       stalls_on;
  int       burst_left;
  int       gap_left;
  logic [7:0] stall_bits;
  int       stall_age;
  bit       word_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: applies one accepted word and returns the result word it causes.
  function automatic timer_result_t apply_word(timer_word_t w);
    timer_result_t r;
    logic          in_bank;
    r       = '0;
    in_bank = (w.timer_index < NUM_TIMERS);
    case (w.mode)
      MODE_TICK: begin
        osc_now = osc_now + 1'b1;
        if (osc_now == match_at) match_latched = 1'b1;
      end
      MODE_SET: if (in_bank) begin
        left_cs[w.timer_index]      = COUNT_WIDTH'(w.count);
        expired_bits[w.timer_index] = 1'b0;
      end
      MODE_CLEAR: if (in_bank) begin
        left_cs[w.timer_index]      = '0;
        expired_bits[w.timer_index] = 1'b0;
      end
      default: if (match_latched) begin
        // A serviced match moves every running timer one centisecond on.
        match_latched = 1'b0;
        match_at      = match_at + step_size;
        cs_total      = cs_total + 1'b1;
        services_n++;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (left_cs[i] != '0) begin
            left_cs[i] = left_cs[i] - 1'b1;
            if (left_cs[i] == '0) begin
              expired_bits[i] = 1'b1;
              if (i < MASK_W && notify_bits[i]) r.expired_mask[i] = 1'b1;
            end
          end
        end
      end
    endcase
    notified_n     += $countones(r.expired_mask);
    r.status       = in_bank ? expired_bits[w.timer_index] : 1'b0;
    r.centiseconds = cs_total;
    r.counter_now  = osc_now;
    return r;
  endfunction

  task automatic reset_prediction();
    for (int i = 0; i < NUM_TIMERS; i++) left_cs[i] = '0;
    expired_bits  = '0;
    cs_total      = '0;
    osc_now       = '0;
    match_at      = RESET_INCREMENT;
    match_latched = 1'b0;
    step_size     = RESET_INCREMENT;
    notify_bits   = '0;
    gen_osc       = '0;
    gen_match     = RESET_INCREMENT;
    gen_step      = RESET_INCREMENT;
    gen_latched   = 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
               $time, results_checked, what, got, want);
  endtask

  task automatic check_result();
    timer_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("word with nothing predicted", 1, 0);
      return;
    end
    want = awaited_results.pop_front();
    results_checked++;
    if (result_ch.status !== want.status)
      report_mismatch("status", result_ch.status, want.status);
    if (result_ch.expired_mask !== want.expired_mask)
      report_mismatch("expired_mask", result_ch.expired_mask, want.expired_mask);
    if (result_ch.centiseconds !== want.centiseconds)
      report_mismatch("centiseconds", result_ch.centiseconds, want.centiseconds);
    if (result_ch.counter_now !== want.counter_now)
      report_mismatch("counter_now", result_ch.counter_now, want.counter_now);
  endtask

  // Generator side: queue a word and track where the oscillator will stand.
  task automatic queue_word(logic [MODE_W-1:0] m, logic [INDEX_W-1:0] idx,
                            logic [COUNT_IN_W-1:0] c);
    timer_word_t w;
    w.mode        = m;
    w.timer_index = idx;
    w.count       = c;
    pending_words.push_back(w);
    words_queued++;
    if (m == MODE_TICK) begin
      gen_osc = gen_osc + 1'b1;
      if (gen_osc == gen_match) gen_latched = 1'b1;
    end else if (m == MODE_POLL && gen_latched) begin
      gen_latched = 1'b0;
      gen_match   = gen_match + gen_step;
    end
  endtask

  // Mostly short counts so that timers run out, with zero, all ones and full range.
  function automatic logic [COUNT_IN_W-1:0] random_count();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return COUNT_IN_W'($urandom_range(1, 12));
    if (pick == 6) return '0;
    if (pick == 7) return '1;
    return COUNT_IN_W'($urandom);
  endfunction

  task automatic queue_side_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) queue_word(MODE_SET, INDEX_W'($urandom), random_count());
    else if (pick < 7) queue_word(MODE_CLEAR, INDEX_W'($urandom), COUNT_IN_W'($urandom));
    else queue_word(MODE_POLL, INDEX_W'($urandom), COUNT_IN_W'($urandom));
  endtask

  task automatic queue_any_word();
    queue_word(MODE_W'($urandom), INDEX_W'($urandom), random_count());
  endtask

  // One centisecond: ticks up to the armed match with side words mixed in, an
  // occasional overshoot, then the servicing poll and sometimes an empty poll.
  task automatic queue_centisecond(int noise_div);
    logic [TIME_W-1:0] gap;
    int                extra;
    gap = gen_match - gen_osc;
    if (gap == '0 || gap > 40000) begin
      // The match is out of reach; only noise makes sense here.
      repeat (4) queue_any_word();
      return;
    end
    for (int k = 0; k < int'(gap); k++) begin
      if ($urandom_range(1, noise_div) == 1) queue_side_word();
      queue_word(MODE_TICK, INDEX_W'($urandom), COUNT_IN_W'($urandom));
    end
    if (gen_step > 1 && $urandom_range(0, 7) == 0) begin
      extra = $urandom_range(1, (gen_step > 4) ? 3 : int'(gen_step) - 1);
      repeat (extra) queue_word(MODE_TICK, INDEX_W'($urandom), COUNT_IN_W'($urandom));
    end
    queue_word(MODE_POLL, INDEX_W'($urandom), COUNT_IN_W'($urandom));
    if ($urandom_range(0, 5) == 0)
      queue_word(MODE_POLL, INDEX_W'($urandom), COUNT_IN_W'($urandom));
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_words.size() != 0 || item_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TICK_INCREMENT: begin
        step_size = value;
        gen_step  = value;
      end
      CFG_NOTIFY_MASK: notify_bits = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Sender: bursts of words with random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drive_word = pending_words.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= drive_word.mode;
        item_ch.timer_index <= drive_word.timer_index;
        item_ch.count       <= drive_word.count;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = gaps_on ? $urandom_range(1, 6) : 0;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls follow a rotating bit pattern that is redrawn now and then.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (!stalls_on) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= !stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[7:1]};
      stall_age++;
      if (stall_age == 48) begin
        stall_age  = 0;
        stall_bits = 8'($urandom);
      end
    end
  end

  // Monitor: checks result words, then predicts for each accepted input word.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) check_result();
    word_taken = !rst && item_ch.valid && item_ch.ready;
    if (word_taken) begin
      seen_word.mode        = item_ch.mode;
      seen_word.timer_index = item_ch.timer_index;
      seen_word.count       = item_ch.count;
      awaited_results.push_back(apply_word(seen_word));
      words_taken_n++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, awaited_results.size());
      $display("multi_channel_countdown_timer_bank: mismatch");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] phase_steps [PHASES];
    logic [MASK_W-1:0] phase_masks [PHASES];
    int                start_n;

    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    item_ch.valid       = 1'b0;
    item_ch.mode        = '0;
    item_ch.timer_index = '0;
    item_ch.count       = '0;
    result_ch.ready     = 1'b0;
    gaps_on             = 1'b1;
    stalls_on           = 1'b1;
    burst_left          = 0;
    gap_left            = 0;
    stall_bits          = 8'($urandom);
    stall_age           = 0;
    word_taken          = 1'b0;
    words_queued        = 0;
    words_taken_n       = 0;
    results_checked     = 0;
    services_n          = 0;
    notified_n          = 0;
    mismatch_count      = 0;
    cycle_count         = 0;
    reset_prediction();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: empty polls, extreme loads, clears and a tick.
    queue_word(MODE_POLL, 0, 0);
    queue_word(MODE_SET, 0, 1);
    queue_word(MODE_SET, 7, 16'hFFFF);
    queue_word(MODE_SET, 3, 0);
    queue_word(MODE_SET, 5, 16'hAAAA);
    queue_word(MODE_SET, 2, 16'h5555);
    queue_word(MODE_SET, 1, 2);
    queue_word(MODE_POLL, 7, 16'hFFFF);
    queue_word(MODE_CLEAR, 7, 16'hFFFF);
    queue_word(MODE_CLEAR, 4, 0);
    queue_word(MODE_TICK, 6, 16'h1234);
    for (int i = 0; i < NUM_TIMERS; i++) queue_word(MODE_POLL, INDEX_W'(i), '0);
    wait_idle();

    // A new increment leaves the armed match alone, so the first match still
    // comes at the reset value; run the oscillator up to it without idling.
    write_register(CFG_TICK_INCREMENT, 32'd3);
    write_register(CFG_NOTIFY_MASK, 32'hFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++)
      queue_word(MODE_SET, INDEX_W'(i), COUNT_IN_W'($urandom_range(1, 6)));
    queue_centisecond(64);

    // Random phases with short increments and varied notification masks.
    phase_steps[0] = 32'd1;
    phase_steps[1] = 32'd2;
    phase_steps[2] = 32'd5;
    phase_steps[3] = $urandom_range(3, 12);
    phase_steps[4] = 32'd7;
    phase_steps[5] = 32'd1;
    phase_masks[0] = 8'hFF;
    phase_masks[1] = 8'h00;
    phase_masks[2] = 8'hA5;
    phase_masks[3] = 8'($urandom);
    phase_masks[4] = 8'h5A;
    phase_masks[5] = 8'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_register(CFG_TICK_INCREMENT, phase_steps[p]);
      write_register(CFG_NOTIFY_MASK, 32'(phase_masks[p]));
      gaps_on   = (p % 2 == 0);
      stalls_on = (p % 3 != 0);
      start_n   = words_queued;
      while (words_queued - start_n < 200) queue_centisecond(6);
    end

    // Zero increment: the match stays put after its service and is then passed.
    wait_idle();
    write_register(CFG_TICK_INCREMENT, 32'd0);
    write_register(CFG_NOTIFY_MASK, 32'($urandom_range(0, 255)));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    queue_centisecond(6);
    repeat (10) queue_any_word();

    // Largest increment with notification off; only noise is left to send.
    wait_idle();
    write_register(CFG_TICK_INCREMENT, 32'hFFFF_FFFF);
    write_register(CFG_NOTIFY_MASK, 32'd0);
    repeat (30) queue_any_word();
    wait_idle();

    $display("Checked %0d results of %0d words: %0d centisecond services, %0d notified",
             results_checked, words_taken_n, services_n, notified_n);
    $display("expiries, tick increments from zero to all ones, masks from none to all.");
    if (mismatch_count == 0) begin
      $display("multi_channel_countdown_timer_bank: match");
    end else begin
      $display("multi_channel_countdown_timer_bank: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mctb_pkg.sv
hw/rtl/mctb_if.sv
hw/rtl/mctb_datapath.sv
hw/rtl/mctb_ctrl.sv
hw/rtl/multi_channel_countdown_timer_bank.sv
verif/testbench.sv
